// ----- design/gradient_kernel_3x3_stream_unit_defines.svh -----
// Assertion macros shared by the gradient kernel design files.
// No dependencies; included by each module that asserts.
`ifndef GRADIENT_KERNEL_3X3_STREAM_UNIT_DEFINES_SVH
`define GRADIENT_KERNEL_3X3_STREAM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define GK3_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error("gk3 check failed");
`define GK3_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error("gk3 forbidden");
`else
`define GK3_ASSERT(lbl, ck, rs, prop)
`define GK3_NEVER(lbl, ck, rs, cond)
`endif

`endif

// ----- design/gk3_pkg.sv -----
// Types and constants of the 3x3 gradient kernel stream unit.
// No dependencies; imported by every module of the block.
package gk3_pkg;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 11;
  localparam int COL_W  = 11;
  localparam int MODE_W = 3;
  localparam int SIZE_W = 12;

  localparam int JOBQ_DEPTH = 4;
  localparam int JQ_PW      = $clog2(JOBQ_DEPTH);
  localparam int JQ_CW      = $clog2(JOBQ_DEPTH + 1);
  localparam int OCC_W      = JQ_CW + 1;

  localparam logic [MODE_W-1:0] MODE_PASS   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PREW_X = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PREW_Y = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SOB_X  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SOB_Y  = 3'd4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_ZERO,
    OP_PREW_X,
    OP_PREW_Y,
    OP_SOB_X,
    OP_SOB_Y
  } op_t;

  // one accepted item's results: up to a kernel/pass result and a border zero
  typedef struct packed {
    logic             has_a;
    logic [ROW_W-1:0] a_row;
    logic [COL_W-1:0] a_col;
    logic [PIX_W-1:0] a_val;
    logic             has_b;
    logic [ROW_W-1:0] b_row;
    logic [COL_W-1:0] b_col;
  } job_t;

endpackage

// ----- design/gk3_job_queue.sv -----
// Short job queue between the front and back parts.
// Depends on gk3_pkg and the assertion macro header.
`include "gradient_kernel_3x3_stream_unit_defines.svh"

module gk3_job_queue
  import gk3_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  job_t             push_job,
  input  logic             pop,
  output job_t             head,
  output logic             empty,
  output logic [JQ_CW-1:0] count
);

  job_t             slots [JOBQ_DEPTH];
  logic [JQ_PW-1:0] wr_ptr;
  logic [JQ_PW-1:0] rd_ptr;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + JQ_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + JQ_PW'(1);
      end
      if (push && !pop) begin
        count <= count + JQ_CW'(1);
      end else if (pop && !push) begin
        count <= count - JQ_CW'(1);
      end
    end
  end

  `GK3_NEVER(a_q_overflow, clk, rst, push && !pop && count == JQ_CW'(JOBQ_DEPTH))

endmodule

// ----- design/gk3_front.sv -----
// Front part: accepts pixels, tracks position, holds line buffers and the
// 3x3 window, evaluates the kernel and posts jobs. Depends on gk3_pkg.
`include "gradient_kernel_3x3_stream_unit_defines.svh"

module gk3_front
  import gk3_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [MODE_W-1:0] mode,
  input  logic [SIZE_W-1:0] image_width,
  input  logic [SIZE_W-1:0] image_height,
  input  logic              push,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              frame_start,
  output logic              full,
  input  logic [JQ_CW-1:0]  q_count,
  output logic              job_push,
  output job_t              job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int HW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] col_base, col0;
  logic [RW-1:0] row_base, row0;
  logic [WW-1:0] c_inc;
  logic [HW-1:0] r_inc;
  logic          accept;
  logic          acc_border;
  logic          acc_inner;
  op_t           acc_op;
  logic [OCC_W-1:0] occ;

  logic             p1_valid;
  logic [PIX_W-1:0] p1_px;
  logic [ROW_W-1:0] p1_row;
  logic [COL_W-1:0] p1_col;
  logic [CW-1:0]    p1_addr;
  op_t              p1_op;
  logic             p1_border;
  logic             p1_inner;

  logic             p2_valid;
  logic [PIX_W-1:0] p2_px;
  logic [ROW_W-1:0] p2_row;
  logic [COL_W-1:0] p2_col;
  op_t              p2_op;
  logic             p2_border;
  logic             p2_inner;

  logic [2*PIX_W-1:0] lbuf [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic               fwd;
  logic [2*PIX_W-1:0] fwd_data;
  logic [PIX_W-1:0]   col_prev, col_prev2;
  logic [PIX_W-1:0]   win [3][3];

  logic [PIX_W-1:0] outer, mid, ksum;
  logic             is_x, is_sob;

  // sizes and position
  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (HW'(image_height) > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  always_comb begin
    col_base = frame_start ? '0 : col_count;
    row_base = frame_start ? '0 : row_count;
    col0 = (WW'(col_base) >= w_eff) ? '0 : col_base;
    row0 = (HW'(row_base) >= h_eff) ? '0 : row_base;
    c_inc = WW'(col0) + WW'(1);
    r_inc = HW'(row0) + HW'(1);
    if (c_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end else begin
      col_count_next = c_inc[CW-1:0];
      row_count_next = row0;
    end
    acc_border = (row0 == '0) || (col0 == '0) ||
                 (HW'(row0) == h_eff - HW'(1)) || (WW'(col0) == w_eff - WW'(1));
    acc_inner  = (row0 >= RW'(2)) && (col0 >= CW'(2));
  end

  always_comb begin
    unique case (mode)
      MODE_PASS:   acc_op = OP_PASS;
      MODE_PREW_X: acc_op = OP_PREW_X;
      MODE_PREW_Y: acc_op = OP_PREW_Y;
      MODE_SOB_X:  acc_op = OP_SOB_X;
      MODE_SOB_Y:  acc_op = OP_SOB_Y;
      default:     acc_op = OP_ZERO;
    endcase
  end

  // room for every item already in flight
  assign occ    = OCC_W'(q_count) + OCC_W'(p1_valid) + OCC_W'(p2_valid);
  assign full   = (occ >= OCC_W'(JOBQ_DEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
    end else begin
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      p1_valid <= accept;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_px     <= pixel;
      p1_row    <= ROW_W'(row0);
      p1_col    <= COL_W'(col0);
      p1_addr   <= col0;
      p1_op     <= acc_op;
      p1_border <= acc_border;
      p1_inner  <= acc_inner;
    end
    p2_px     <= p1_px;
    p2_row    <= p1_row;
    p2_col    <= p1_col;
    p2_op     <= p1_op;
    p2_border <= p1_border;
    p2_inner  <= p1_inner;
  end

  // line buffers: {two rows up, one row up} per column
  assign col_prev  = fwd ? fwd_data[PIX_W-1:0]       : rd_q[PIX_W-1:0];
  assign col_prev2 = fwd ? fwd_data[2*PIX_W-1:PIX_W] : rd_q[2*PIX_W-1:PIX_W];

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      lbuf[p1_addr] <= {col_prev, p1_px};
    end
    if (accept) begin
      rd_q     <= lbuf[col0];
      fwd      <= p1_valid && (p1_addr == col0);
      fwd_data <= {col_prev, p1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= col_prev2;
      win[1][2] <= col_prev;
      win[2][2] <= p1_px;
    end
  end

  // kernel sum, wrapped to a byte
  always_comb begin
    is_x   = (p2_op == OP_PREW_X) || (p2_op == OP_SOB_X);
    is_sob = (p2_op == OP_SOB_X) || (p2_op == OP_SOB_Y);
    if (is_x) begin
      outer = win[0][2] + win[2][2] - win[0][0] - win[2][0];
      mid   = win[1][2] - win[1][0];
    end else begin
      outer = win[2][0] + win[2][2] - win[0][0] - win[0][2];
      mid   = win[2][1] - win[0][1];
    end
    ksum = is_sob ? outer + {mid[PIX_W-2:0], 1'b0} : outer + mid;
  end

  always_comb begin
    job.a_row = p2_row;
    job.a_col = p2_col;
    job.b_row = p2_row;
    job.b_col = p2_col;
    job.has_b = 1'b0;
    case (p2_op)
      OP_PASS: begin
        job.has_a = 1'b1;
        job.a_val = p2_px;
      end
      OP_ZERO: begin
        job.has_a = 1'b1;
        job.a_val = '0;
      end
      default: begin
        job.has_a = p2_inner;
        job.a_row = p2_row - ROW_W'(1);
        job.a_col = p2_col - COL_W'(1);
        job.a_val = ksum;
        job.has_b = p2_border;
      end
    endcase
  end

  assign job_push = p2_valid && (job.has_a || job.has_b);

  `GK3_ASSERT(a_credit, clk, rst, occ <= OCC_W'(JOBQ_DEPTH))

endmodule

// ----- design/gk3_back.sv -----
// Back part: splits each job into result items and holds the output register.
// Depends on gk3_pkg; takes jobs from gk3_job_queue.
`include "gradient_kernel_3x3_stream_unit_defines.svh"

module gk3_back
  import gk3_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  job_t             head,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic [PIX_W-1:0] value,
  output logic             last
);

  logic out_valid;
  logic sub;
  logic sub_next;
  logic take;
  logic load;
  logic sel_b;

  assign empty = !out_valid;
  assign take  = !out_valid || pop;

  always_comb begin
    q_pop    = 1'b0;
    load     = 1'b0;
    sel_b    = 1'b0;
    sub_next = sub;
    if (!q_empty) begin
      if (!sub && head.has_a) begin
        if (take) begin
          load = 1'b1;
          if (head.has_b) begin
            sub_next = 1'b1;
          end else begin
            q_pop = 1'b1;
          end
        end
      end else if (head.has_b) begin
        if (take) begin
          load     = 1'b1;
          sel_b    = 1'b1;
          q_pop    = 1'b1;
          sub_next = 1'b0;
        end
      end else begin
        q_pop    = 1'b1;
        sub_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      sub <= sub_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sel_b) begin
        out_row <= head.b_row;
        out_col <= head.b_col;
        value   <= '0;
        last    <= 1'b1;
      end else begin
        out_row <= head.a_row;
        out_col <= head.a_col;
        value   <= head.a_val;
        last    <= !head.has_b;
      end
    end
  end

  `GK3_NEVER(a_pop_empty, clk, rst, q_pop && q_empty)
  `GK3_ASSERT(a_sub_pending, clk, rst, sub |-> (!q_empty && head.has_b))

endmodule

// ----- design/gradient_kernel_3x3_stream_unit.sv -----
// Top level of the 3x3 gradient kernel stream unit: register port and wiring.
// Depends on gk3_pkg, gk3_front, gk3_job_queue and gk3_back.
//
// Pixels enter in raster order, one per clock while full is low; a result
// passes p1, p2, the job queue and the output register. Items that cause
// one result sustain one item per clock while pop keeps up. In the kernel
// modes an item on the last column (from row two) or on the last row (from
// column two) causes two results, which use the single result port in turn;
// the four-entry job queue absorbs short bursts of these. Both line buffers
// share one MAX_WIDTH x 16 memory with one read and one write per clock,
// and need no clearing after reset. Registers: mode at 0x0, image_width at
// 0x4, image_height at 0x8; write them only while the block is idle.
module gradient_kernel_3x3_stream_unit
  import gk3_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel,
  input  logic             frame_start,
  output logic             empty,
  input  logic             pop,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic [PIX_W-1:0] value,
  output logic             last
);

  logic [MODE_W-1:0] mode;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  job_t             job;
  logic             job_push;
  job_t             head;
  logic             q_empty;
  logic             q_pop;
  logic [JQ_CW-1:0] q_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_PASS;
      image_width  <= SIZE_W'(2048);
      image_height <= SIZE_W'(2048);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:   mode         <= pwdata[MODE_W-1:0];
        REG_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = 32'(mode);
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  gk3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .image_width  (image_width),
    .image_height (image_height),
    .push         (push),
    .pixel        (pixel),
    .frame_start  (frame_start),
    .full         (full),
    .q_count      (q_count),
    .job_push     (job_push),
    .job          (job)
  );

  gk3_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .count    (q_count)
  );

  gk3_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_row (out_row),
    .out_col (out_col),
    .value   (value),
    .last    (last)
  );

endmodule
